// ===== sv/itda_pkg.sv =====
// Shared types and constants for the integer to decimal text converter.
`timescale 1ns / 1ps

package itda_pkg;

    localparam int MAG_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(MAG_W);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W     = 6;

    localparam logic [CHAR_W-1:0] CODE_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CODE_ZERO  = 6'd48;

    // Converted magnitude handed from the shifter to the emitter
    typedef struct packed {
        logic             valid;
        logic             negative;
        logic [BCD_W-1:0] bcd;
    } bcd_result_t;

endpackage

// ===== sv/itda_dabble.sv =====
// Bit-serial binary to BCD shifter (shift-and-add-3), one input bit per cycle.
`timescale 1ns / 1ps

module itda_dabble
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       negative,
    input  logic [itda_pkg::MAG_W-1:0] mag,
    output itda_pkg::bcd_result_t      result
);
    import itda_pkg::*;

    logic [MAG_W-1:0] bin_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_adj;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic             neg_reg;

    // Add three to every digit of five or more before the shift
    always_comb
    begin
        logic [3:0] d;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bin_reg <= mag;
            bcd_reg <= '0;
            neg_reg <= negative;
        end
        else if (run_reg)
        begin
            bin_reg <= {bin_reg[MAG_W-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[MAG_W-1]};
        end
    end

    assign result.valid    = done_reg;
    assign result.negative = neg_reg;
    assign result.bcd      = bcd_reg;

endmodule

// ===== sv/itda_emit.sv =====
// Character emitter: sign, leading-zero skip, then one digit per cycle.
`timescale 1ns / 1ps

module itda_emit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  itda_pkg::bcd_result_t       result,
    output logic                        strobe,
    output logic [itda_pkg::CHAR_W-1:0] char_code,
    output logic                        last,
    output logic                        finish
);
    import itda_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    logic [BCD_W-1:0]  digits_reg;
    logic [LEFT_W-1:0] left_reg;
    logic              strobe_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic              finish_reg;
    logic [3:0]        top_digit;

    assign top_digit = digits_reg[BCD_W-1 -: 4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            finish_reg <= 1'b0;
            left_reg   <= '0;
            digits_reg <= '0;
            char_reg   <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            finish_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (result.valid)
                    begin
                        digits_reg <= result.bcd;
                        left_reg   <= LEFT_W'(NUM_DIGITS);
                        state_reg  <= result.negative ? ST_SIGN : ST_SKIP;
                    end
                end
                ST_SIGN:
                begin
                    strobe_reg <= 1'b1;
                    char_reg   <= CODE_MINUS;
                    state_reg  <= ST_SKIP;
                end
                ST_SKIP:
                begin
                    // drop leading zeros but keep at least one digit
                    if (top_digit == 4'd0 && left_reg != LEFT_W'(1))
                    begin
                        digits_reg <= {digits_reg[BCD_W-5:0], 4'd0};
                        left_reg   <= left_reg - 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    strobe_reg <= 1'b1;
                    char_reg   <= CODE_ZERO + CHAR_W'(top_digit);
                    digits_reg <= {digits_reg[BCD_W-5:0], 4'd0};
                    left_reg   <= left_reg - 1'b1;
                    if (left_reg == LEFT_W'(1))
                    begin
                        last_reg   <= 1'b1;
                        finish_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last      = last_reg;
    assign finish    = finish_reg;

endmodule

// ===== sv/int_to_decimal_ascii_core.sv =====
// Top level of the signed 32-bit integer to decimal ASCII converter.
`timescale 1ns / 1ps
//
// Usage:
//   Request channel: drive value and raise start; the request is taken at a
//   rising edge where start is high and busy is low. busy then stays high
//   until the final character of that request has been presented.
//   Result channel: each character appears on char_code for one cycle with
//   strobe high; last marks the final character of the run. The receiver
//   cannot hold results off, so every strobed cycle must be captured.
//   Text: '-' first for a negative value, then the decimal digits, most
//   significant first, with leading zeros dropped (zero gives one '0').
// Timing:
//   The magnitude passes through a bit-serial shift-and-add-3 converter,
//   one bit per cycle; a registered done flag then hands the BCD digits
//   to the emitter. The emitter shows the sign, drops the leading zeros
//   one at a time, and then shows the digits that remain. A new request
//   cannot be taken until the run is over: at best, the next one is taken
//   at the end of the cycle after the last character is shown.
// Reset: rst_n clears busy and all strobes; any run in progress is dropped.

module int_to_decimal_ascii_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          value,
    output logic                        strobe,
    output logic [itda_pkg::CHAR_W-1:0] char_code,
    output logic                        last
);
    import itda_pkg::*;

    logic             accept;
    logic             negative;
    logic [MAG_W-1:0] mag;
    logic             busy_reg;
    logic             busy_next;
    logic             finish;
    bcd_result_t      result;

    assign accept = start && !busy_reg;

    // Form the magnitude in unsigned arithmetic so the most negative value
    // gives 2147483648 without overflow.
    assign negative = value[MAG_W-1];
    assign mag      = negative ? (~MAG_W'(value) + 1'b1) : MAG_W'(value);

    // Hold busy from the request until the emitter finishes the last digit
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;

    itda_dabble u_dabble
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .negative (negative),
        .mag      (mag),
        .result   (result)
    );

    itda_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .strobe    (strobe),
        .char_code (char_code),
        .last      (last),
        .finish    (finish)
    );

    // A character is only ever shown while its request is still in hand
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("character shown with no request in progress");

    // The final character releases the block
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !busy)
        else $error("busy still high after final character");

    // A fresh request cannot yield a character in the next cycle
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !strobe)
        else $error("character shown straight after a request");

    // The sign is never the final character
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && char_code == CODE_MINUS) |-> !last)
        else $error("minus sign flagged as final character");

endmodule
